// File: rtl/acns_pkg.sv
// Package for the ADC channel noise statistics unit.
// It holds shared widths, limits, register indexes, item opcodes, the sequencer states and the divider structs.
// It depends on nothing.
package acns_pkg;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned CountW   = 16;
  localparam int unsigned SumW     = 28;
  localparam int unsigned SumSqW   = 40;
  localparam int unsigned MeanW    = 20;
  localparam int unsigned DvdW     = 56;
  localparam int unsigned DvsW     = 16;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned NormMaxDefault = 1000;

  localparam logic [SampleW-1:0] SampleMax = 12'hFFF;
  localparam logic [CountW-1:0]  CountMax  = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCalLow    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCalHigh   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvert    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd3;

  // Item opcodes.
  localparam logic OpAdd  = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StNorm,
    StNormWait,
    StAdd,
    StRead,
    StMul,
    StSqStart,
    StSqWait,
    StMeanWait,
    StDone
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  // Response of the shared divider.
  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/acns_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// It depends on acns_pkg for widths and the request and response structs.
module acns_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acns_pkg::div_req_t  req_i,
  output acns_pkg::div_rsp_t  rsp_o
);

  localparam logic [acns_pkg::DivCntW-1:0] LastCnt = acns_pkg::DivCntW'(acns_pkg::DvdW - 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [acns_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic [acns_pkg::DvdW-1:0]     dvd_q, dvd_d;
  logic [acns_pkg::DvsW-1:0]     rem_q, rem_d;
  logic [acns_pkg::DvsW-1:0]     dvs_q, dvs_d;
  logic [acns_pkg::DvsW:0]       rem_sh;

  // One shift and trial subtraction per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, dvd_q[acns_pkg::DvdW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = acns_pkg::DvsW'(rem_sh - {1'b0, dvs_q});
        dvd_d = {dvd_q[acns_pkg::DvdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[acns_pkg::DvsW-1:0];
        dvd_d = {dvd_q[acns_pkg::DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// File: rtl/adc_channel_noise_statistics_unit.sv
// Top level of the ADC channel noise statistics unit.
// It depends on acns_pkg and on the shared divider acns_div.
//
// One transaction is taken at a time; in_ready_o is low while it is worked on.
// An add transaction makes one 56-step pass of the shared bit-serial divider for
// normalization when the calibration span is positive, and skips it otherwise. A
// read transaction of a non-empty bank runs a 28-step shift-add squaring of the
// sum and two 56-step divider passes (sum squared over count, and the Q12.8
// mean); an empty bank skips these and goes straight to its result.
// The result is held in an output register, so a new transaction can be taken
// while a result waits; a later read waits at its end until that slot is free.
module adc_channel_noise_statistics_unit #(
  parameter int unsigned NORM_MAX = acns_pkg::NormMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic        phase_i,
  input  logic [11:0] raw_sample_i,
  input  logic [11:0] filtered_sample_i,
  input  logic [11:0] ui_level_i,
  input  logic        signal_pick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] sample_total_o,
  output logic [11:0] lowest_o,
  output logic [11:0] highest_o,
  output logic [11:0] peak_to_peak_o,
  output logic [19:0] mean_q8_o,
  output logic [39:0] squared_deviation_sum_o,
  output logic [11:0] largest_step_o,
  output logic [15:0] trigger_total_o
);

  localparam int unsigned SW = acns_pkg::SampleW;
  localparam int unsigned ProdW = 2 * SW + 1;
  localparam logic [SW-1:0] NormMax = SW'(NORM_MAX);
  localparam logic [4:0] MulLast = 5'(acns_pkg::SumW - 1);

  acns_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [SW-1:0] cal_low_q, cal_high_q, thr_q;
  logic          invert_q;

  // Captured transaction.
  logic          ph_q, pick_q;
  logic [SW-1:0] raw_q, filt_q, ui_q;

  // Bank state.
  logic [acns_pkg::CountW-1:0] count_q [2];
  logic                        has_prior_q [2];
  logic [SW-1:0]               prior_norm_q [2];
  logic [SW-1:0]               prior_ui_q [2];

  // Per-signal state, index phase*2 + signal.
  logic [SW-1:0]               sig_min_q [4];
  logic [SW-1:0]               sig_max_q [4];
  logic [acns_pkg::SumW-1:0]   sig_sum_q [4];
  logic [acns_pkg::SumSqW-1:0] sig_sq_q [4];
  logic [SW-1:0]               sig_prior_q [4];
  logic [SW-1:0]               sig_step_q [4];
  logic [acns_pkg::CountW-1:0] sig_trig_q [4];

  // Read datapath.
  logic [acns_pkg::DvdW-1:0]  mcand_q, acc_q, sqq_q;
  logic [acns_pkg::SumW-1:0]  mplier_q;
  logic [4:0]                 mul_cnt_q;
  logic [acns_pkg::MeanW-1:0] mean_hold_q;

  // Output register.
  logic                        out_valid_q;
  logic [acns_pkg::CountW-1:0] o_total_q, o_trig_q;
  logic [SW-1:0]               o_low_q, o_high_q, o_p2p_q, o_step_q;
  logic [acns_pkg::MeanW-1:0]  o_mean_q;
  logic [acns_pkg::SumSqW-1:0] o_m2_q;

  acns_pkg::div_req_t div_req;
  acns_pkg::div_rsp_t div_rsp;

  acns_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic in_fire, out_free, span_ok;
  assign in_ready_o = (state_q == acns_pkg::StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign span_ok    = cal_high_q > cal_low_q;

  // Normalization numerator from the clamped raw sample.
  logic [SW-1:0]    clamped, span;
  logic [ProdW-1:0] norm_num;
  always_comb begin
    if (raw_q < cal_low_q) begin
      clamped = cal_low_q;
    end else if (raw_q > cal_high_q) begin
      clamped = cal_high_q;
    end else begin
      clamped = raw_q;
    end
    span     = cal_high_q - cal_low_q;
    norm_num = ProdW'(clamped - cal_low_q) * ProdW'(NormMax) + ProdW'(span >> 1);
  end

  // Normalized value, taken from the divider when the span is positive.
  logic [SW-1:0] norm_base, norm_val;
  always_comb begin
    norm_base = span_ok ? div_rsp.quotient[SW-1:0] : '0;
    norm_val  = invert_q ? (NormMax - norm_base) : norm_base;
  end

  // Bank and signal addressing.
  logic [1:0] rd_idx;
  logic [acns_pkg::CountW-1:0] n_cur;
  logic [acns_pkg::DvdW-1:0] half_n;
  assign rd_idx = {ph_q, pick_q};
  assign n_cur  = count_q[ph_q];
  assign half_n = acns_pkg::DvdW'(n_cur >> 1);

  // Divider requests.
  always_comb begin
    div_req = '0;
    if (state_q == acns_pkg::StNorm) begin
      div_req.start    = 1'b1;
      div_req.dividend = acns_pkg::DvdW'(norm_num);
      div_req.divisor  = acns_pkg::DvsW'(span);
    end else if (state_q == acns_pkg::StSqStart) begin
      div_req.start    = 1'b1;
      div_req.dividend = acc_q + half_n;
      div_req.divisor  = n_cur;
    end else if (state_q == acns_pkg::StSqWait && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = acns_pkg::DvdW'({sig_sum_q[rd_idx], 8'h00}) + half_n;
      div_req.divisor  = n_cur;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acns_pkg::StIdle: begin
        if (in_fire) begin
          state_d = (opcode_i == acns_pkg::OpAdd) ? acns_pkg::StNorm : acns_pkg::StRead;
        end
      end
      acns_pkg::StNorm: begin
        state_d = span_ok ? acns_pkg::StNormWait : acns_pkg::StAdd;
      end
      acns_pkg::StNormWait: begin
        if (div_rsp.done) begin
          state_d = acns_pkg::StAdd;
        end
      end
      acns_pkg::StAdd: state_d = acns_pkg::StIdle;
      acns_pkg::StRead: begin
        state_d = (n_cur == '0) ? acns_pkg::StDone : acns_pkg::StMul;
      end
      acns_pkg::StMul: begin
        if (mul_cnt_q == MulLast) begin
          state_d = acns_pkg::StSqStart;
        end
      end
      acns_pkg::StSqStart: state_d = acns_pkg::StSqWait;
      acns_pkg::StSqWait: begin
        if (div_rsp.done) begin
          state_d = acns_pkg::StMeanWait;
        end
      end
      acns_pkg::StMeanWait: begin
        if (div_rsp.done) begin
          state_d = acns_pkg::StDone;
        end
      end
      acns_pkg::StDone: begin
        if (out_free) begin
          state_d = acns_pkg::StIdle;
        end
      end
      default: state_d = acns_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acns_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= '0;
      cal_high_q <= acns_pkg::SampleMax;
      invert_q   <= 1'b0;
      thr_q      <= SW'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        acns_pkg::CfgCalLow:    cal_low_q  <= cfg_wdata_i;
        acns_pkg::CfgCalHigh:   cal_high_q <= cfg_wdata_i;
        acns_pkg::CfgInvert:    invert_q   <= cfg_wdata_i[0];
        acns_pkg::CfgThreshold: thr_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Transaction capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ph_q   <= phase_i;
      pick_q <= signal_pick_i;
      raw_q  <= raw_sample_i;
      filt_q <= filtered_sample_i;
      ui_q   <= ui_level_i;
    end
  end

  // Trigger decisions and per-signal values for an add.
  logic          hp, acc_ok, raw_trig, filt_trig;
  logic [SW-1:0] d_norm, d_ui;
  logic [SW-1:0] add_v [2];
  logic          add_trig [2];
  always_comb begin
    hp     = has_prior_q[ph_q];
    acc_ok = count_q[ph_q] != acns_pkg::CountMax;
    d_norm = (norm_val > prior_norm_q[ph_q]) ? (norm_val - prior_norm_q[ph_q])
                                             : (prior_norm_q[ph_q] - norm_val);
    d_ui   = (ui_q > prior_ui_q[ph_q]) ? (ui_q - prior_ui_q[ph_q])
                                       : (prior_ui_q[ph_q] - ui_q);
    raw_trig    = hp && (d_norm >= thr_q);
    filt_trig   = hp && (d_ui >= thr_q);
    add_v[0]    = raw_q;
    add_v[1]    = filt_q;
    add_trig[0] = raw_trig;
    add_trig[1] = filt_trig;
  end

  // Bank and signal statistics update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        count_q[b]      <= '0;
        has_prior_q[b]  <= 1'b0;
        prior_norm_q[b] <= '0;
        prior_ui_q[b]   <= '0;
      end
      for (int s = 0; s < 4; s++) begin
        sig_min_q[s]   <= acns_pkg::SampleMax;
        sig_max_q[s]   <= '0;
        sig_sum_q[s]   <= '0;
        sig_sq_q[s]    <= '0;
        sig_prior_q[s] <= '0;
        sig_step_q[s]  <= '0;
        sig_trig_q[s]  <= '0;
      end
    end else if (state_q == acns_pkg::StAdd) begin
      if (acc_ok) begin
        count_q[ph_q] <= count_q[ph_q] + 1'b1;
      end
      has_prior_q[ph_q]  <= 1'b1;
      prior_norm_q[ph_q] <= norm_val;
      prior_ui_q[ph_q]   <= ui_q;
      for (int k = 0; k < 2; k++) begin
        if (add_v[k] < sig_min_q[{ph_q, k[0]}]) begin
          sig_min_q[{ph_q, k[0]}] <= add_v[k];
        end
        if (add_v[k] > sig_max_q[{ph_q, k[0]}]) begin
          sig_max_q[{ph_q, k[0]}] <= add_v[k];
        end
        if (acc_ok) begin
          sig_sum_q[{ph_q, k[0]}] <= sig_sum_q[{ph_q, k[0]}] + acns_pkg::SumW'(add_v[k]);
          sig_sq_q[{ph_q, k[0]}]  <= sig_sq_q[{ph_q, k[0]}]
                                     + acns_pkg::SumSqW'(add_v[k])
                                     * acns_pkg::SumSqW'(add_v[k]);
        end
        if (hp) begin
          if (((add_v[k] > sig_prior_q[{ph_q, k[0]}])
                ? (add_v[k] - sig_prior_q[{ph_q, k[0]}])
                : (sig_prior_q[{ph_q, k[0]}] - add_v[k])) > sig_step_q[{ph_q, k[0]}]) begin
            sig_step_q[{ph_q, k[0]}] <= (add_v[k] > sig_prior_q[{ph_q, k[0]}])
                                        ? (add_v[k] - sig_prior_q[{ph_q, k[0]}])
                                        : (sig_prior_q[{ph_q, k[0]}] - add_v[k]);
          end
          if (add_trig[k] && (sig_trig_q[{ph_q, k[0]}] != acns_pkg::CountMax)) begin
            sig_trig_q[{ph_q, k[0]}] <= sig_trig_q[{ph_q, k[0]}] + 1'b1;
          end
        end
        sig_prior_q[{ph_q, k[0]}] <= add_v[k];
      end
    end
  end

  // Shift-add squaring of the sum, and the held quotients.
  always_ff @(posedge clk_i) begin
    if (state_q == acns_pkg::StRead) begin
      mcand_q   <= acns_pkg::DvdW'(sig_sum_q[rd_idx]);
      mplier_q  <= sig_sum_q[rd_idx];
      acc_q     <= '0;
      mul_cnt_q <= '0;
    end else if (state_q == acns_pkg::StMul) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q   <= {mcand_q[acns_pkg::DvdW-2:0], 1'b0};
      mplier_q  <= mplier_q >> 1;
      mul_cnt_q <= mul_cnt_q + 1'b1;
    end
    if (state_q == acns_pkg::StSqWait && div_rsp.done) begin
      sqq_q <= div_rsp.quotient;
    end
    if (state_q == acns_pkg::StMeanWait && div_rsp.done) begin
      mean_hold_q <= div_rsp.quotient[acns_pkg::MeanW-1:0];
    end
  end

  // Result register.
  logic empty;
  logic [acns_pkg::DvdW-1:0] sq_ext;
  assign empty  = (n_cur == '0);
  assign sq_ext = acns_pkg::DvdW'(sig_sq_q[rd_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == acns_pkg::StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == acns_pkg::StDone && out_free) begin
      o_total_q <= n_cur;
      o_low_q   <= sig_min_q[rd_idx];
      o_high_q  <= sig_max_q[rd_idx];
      o_step_q  <= sig_step_q[rd_idx];
      o_trig_q  <= sig_trig_q[rd_idx];
      if (empty) begin
        o_mean_q <= '0;
        o_m2_q   <= '0;
        o_p2p_q  <= '0;
      end else begin
        o_mean_q <= mean_hold_q;
        o_m2_q   <= (sq_ext >= sqq_q) ? acns_pkg::SumSqW'(sq_ext - sqq_q) : '0;
        o_p2p_q  <= (sig_max_q[rd_idx] >= sig_min_q[rd_idx])
                    ? (sig_max_q[rd_idx] - sig_min_q[rd_idx]) : '0;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign sample_total_o          = o_total_q;
  assign lowest_o                = o_low_q;
  assign highest_o               = o_high_q;
  assign peak_to_peak_o          = o_p2p_q;
  assign mean_q8_o               = o_mean_q;
  assign squared_deviation_sum_o = o_m2_q;
  assign largest_step_o          = o_step_q;
  assign trigger_total_o         = o_trig_q;

endmodule

// File: tb/adc_channel_noise_statistics_checker.sv
// Checker for the ADC channel noise statistics unit: it tracks accepted transactions,
// predicts each read summary from its own copy of the bank state, and compares results.
// It depends on acns_pkg.
module adc_channel_noise_statistics_checker #(
  parameter int unsigned NORM_MAX = acns_pkg::NormMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        opcode_i,
  input  logic        phase_i,
  input  logic [11:0] raw_sample_i,
  input  logic [11:0] filtered_sample_i,
  input  logic [11:0] ui_level_i,
  input  logic        signal_pick_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] sample_total_i,
  input  logic [11:0] lowest_i,
  input  logic [11:0] highest_i,
  input  logic [11:0] peak_to_peak_i,
  input  logic [19:0] mean_q8_i,
  input  logic [39:0] squared_deviation_sum_i,
  input  logic [11:0] largest_step_i,
  input  logic [15:0] trigger_total_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          summaries_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] total;
    logic [11:0] lo;
    logic [11:0] hi;
    logic [11:0] p2p;
    logic [19:0] mean;
    logic [39:0] m2;
    logic [11:0] step;
    logic [15:0] trig;
  } summary_t;

  // Mirrored configuration.
  logic [11:0] cal_lo, cal_hi, thresh;
  logic        inv;

  // Mirrored bank and signal state.
  logic [15:0] cnt [2];
  logic        primed [2];
  logic [11:0] last_norm [2];
  logic [11:0] last_ui [2];
  logic [11:0] s_min [4];
  logic [11:0] s_max [4];
  logic [27:0] s_sum [4];
  logic [39:0] s_sq [4];
  logic [11:0] s_last [4];
  logic [11:0] s_step [4];
  logic [15:0] s_trig [4];

  summary_t expected_summaries [$];

  function automatic logic [11:0] gap(logic [11:0] a, logic [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Calibrated position of a raw reading on the 0..NORM_MAX scale.
  function automatic logic [11:0] scale_raw(logic [11:0] raw);
    int unsigned c, span, v;
    v = 0;
    if (cal_hi > cal_lo) begin
      c = (raw < cal_lo) ? cal_lo : ((raw > cal_hi) ? cal_hi : raw);
      span = cal_hi - cal_lo;
      v = ((c - cal_lo) * NORM_MAX + span / 2) / span;
    end
    if (inv) v = NORM_MAX - v;
    return v[11:0];
  endfunction

  task automatic fold_sample(int s, logic [11:0] v, logic has_prev, logic acc, logic trig);
    if (v < s_min[s]) s_min[s] = v;
    if (v > s_max[s]) s_max[s] = v;
    if (acc) begin
      s_sum[s] = s_sum[s] + 28'(v);
      s_sq[s] = s_sq[s] + 40'(v) * 40'(v);
    end
    if (has_prev) begin
      if (gap(v, s_last[s]) > s_step[s]) s_step[s] = gap(v, s_last[s]);
      if (trig && s_trig[s] != 16'hFFFF) s_trig[s] = s_trig[s] + 16'd1;
    end
    s_last[s] = v;
  endtask

  task automatic apply_transaction();
    logic [11:0] nv;
    logic        hp, acc, rt, ft;
    int          s;
    logic [63:0] n, sum, q, sq;
    summary_t    e;
    if (opcode_i == acns_pkg::OpAdd) begin
      nv  = scale_raw(raw_sample_i);
      hp  = primed[phase_i];
      acc = cnt[phase_i] != acns_pkg::CountMax;
      rt  = hp && (gap(nv, last_norm[phase_i]) >= thresh);
      ft  = hp && (gap(ui_level_i, last_ui[phase_i]) >= thresh);
      if (acc) cnt[phase_i] = cnt[phase_i] + 16'd1;
      fold_sample(phase_i * 2, raw_sample_i, hp, acc, rt);
      fold_sample(phase_i * 2 + 1, filtered_sample_i, hp, acc, ft);
      last_norm[phase_i] = nv;
      last_ui[phase_i]   = ui_level_i;
      primed[phase_i]    = 1'b1;
    end else begin
      s = phase_i * 2 + signal_pick_i;
      n = 64'(cnt[phase_i]);
      e = '0;
      e.total = cnt[phase_i];
      e.lo = s_min[s];
      e.hi = s_max[s];
      e.step = s_step[s];
      e.trig = s_trig[s];
      if (n != 0) begin
        sum = 64'(s_sum[s]);
        sq = 64'(s_sq[s]);
        q = (sum * sum + n / 2) / n;
        e.mean = 20'((sum * 256 + n / 2) / n);
        e.m2 = (sq >= q) ? 40'(sq - q) : '0;
        if (s_max[s] >= s_min[s]) e.p2p = s_max[s] - s_min[s];
      end
      expected_summaries.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    summary_t got, want;
    if (!rst_ni) begin
      cal_lo = 12'd0;
      cal_hi = 12'd4095;
      inv = 1'b0;
      thresh = 12'd5;
      for (int i = 0; i < 2; i++) begin
        cnt[i] = '0; primed[i] = 1'b0; last_norm[i] = '0; last_ui[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
        s_min[i] = acns_pkg::SampleMax; s_max[i] = '0; s_sum[i] = '0; s_sq[i] = '0;
        s_last[i] = '0; s_step[i] = '0; s_trig[i] = '0;
      end
      expected_summaries.delete();
      fail_count_o = 0;
      summaries_seen_o = 0;
      pending_o = 0;
    end else begin
      // Check a finished summary against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        got = {sample_total_i, lowest_i, highest_i, peak_to_peak_i, mean_q8_i,
               squared_deviation_sum_i, largest_step_i, trigger_total_i};
        summaries_seen_o++;
        if (expected_summaries.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("Unexpected summary %h", got);
        end else begin
          want = expected_summaries.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("Summary mismatch: total %0d/%0d lo %0d/%0d hi %0d/%0d p2p %0d/%0d",
                       want.total, got.total, want.lo, got.lo, want.hi, got.hi,
                       want.p2p, got.p2p,
                       "\n  mean %0d/%0d m2 %0d/%0d step %0d/%0d trig %0d/%0d",
                       want.mean, got.mean, want.m2, got.m2, want.step, got.step,
                       want.trig, got.trig);
          end
        end
      end
      // Update state with an accepted transaction.
      if (in_valid_i && in_ready_i) apply_transaction();
      // The bench must make register writes only while the unit is idle; this checker does not enforce it.
      if (cfg_we_i) begin
        case (cfg_index_i)
          acns_pkg::CfgCalLow:    cal_lo = cfg_wdata_i;
          acns_pkg::CfgCalHigh:   cal_hi = cfg_wdata_i;
          acns_pkg::CfgInvert:    inv = cfg_wdata_i[0];
          acns_pkg::CfgThreshold: thresh = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = expected_summaries.size();
    end
  end

endmodule

// File: tb/adc_channel_noise_statistics_unit_tb.sv
// Testbench top for the ADC channel noise statistics unit: drives transactions and register
// writes, applies back-pressure, and reports the verdict. It depends on acns_pkg, the unit and
// adc_channel_noise_statistics_checker.
module adc_channel_noise_statistics_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Deadline = 2_000_000;
  localparam int Drain = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = 1'b0;
  logic        phase_i = 1'b0;
  logic [11:0] raw_sample_i = '0;
  logic [11:0] filtered_sample_i = '0;
  logic [11:0] ui_level_i = '0;
  logic        signal_pick_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] sample_total_o;
  logic [11:0] lowest_o, highest_o, peak_to_peak_o, largest_step_o;
  logic [19:0] mean_q8_o;
  logic [39:0] squared_deviation_sum_o;
  logic [15:0] trigger_total_o;

  int fail_count, pending, summaries_seen;
  int send_idle_pct, recv_idle_pct;
  int hold_off_cycles = 0;
  int cycle_count = 0;
  int items_sent = 0;

  always #5 clk_i = ~clk_i;

  adc_channel_noise_statistics_unit DUT (.*);

  adc_channel_noise_statistics_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .phase_i, .raw_sample_i,
    .filtered_sample_i, .ui_level_i, .signal_pick_i,
    .out_valid_i(out_valid_o), .out_ready_i, .sample_total_i(sample_total_o),
    .lowest_i(lowest_o), .highest_i(highest_o), .peak_to_peak_i(peak_to_peak_o),
    .mean_q8_i(mean_q8_o), .squared_deviation_sum_i(squared_deviation_sum_o),
    .largest_step_i(largest_step_o), .trigger_total_i(trigger_total_o),
    .fail_count_o(fail_count), .pending_o(pending), .summaries_seen_o(summaries_seen)
  );

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > Deadline) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one transaction and wait until it is accepted. Valid stays high after
  // acceptance only when the next transaction follows at once.
  task automatic offer(logic op, logic ph, logic [11:0] raw, logic [11:0] filt,
                       logic [11:0] ui, logic pick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    opcode_i <= op;
    phase_i <= ph;
    raw_sample_i <= raw;
    filtered_sample_i <= filt;
    ui_level_i <= ui;
    signal_pick_i <= pick;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic add_sample(logic ph, logic [11:0] raw, logic [11:0] filt, logic [11:0] ui);
    offer(acns_pkg::OpAdd, ph, raw, filt, ui, 1'($urandom_range(1)));
  endtask

  task automatic read_summary(logic ph, logic pick);
    offer(acns_pkg::OpRead, ph, 12'($urandom), 12'($urandom), 12'($urandom), pick);
  endtask

  // Wait until every predicted summary has arrived and the unit has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_calibration(logic [11:0] lo, logic [11:0] hi, logic inv, logic [11:0] th);
    settle();
    write_reg(acns_pkg::CfgCalLow, lo);
    write_reg(acns_pkg::CfgCalHigh, hi);
    write_reg(acns_pkg::CfgInvert, {11'd0, inv});
    write_reg(acns_pkg::CfgThreshold, th);
    cfg_we_i <= 1'b0;
  endtask

  task automatic read_all();
    for (int p = 0; p < 2; p++)
      for (int k = 0; k < 2; k++) read_summary(p[0], k[0]);
  endtask

  // A burst of samples drifting around a center, with summaries read at random among them.
  task automatic random_burst(int n);
    int base, ui, ph;
    base = $urandom_range(4095);
    ui = $urandom_range(4095);
    ph = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) base = $urandom_range(4095);
      else base = (base + $urandom_range(60) - 30) & 12'hFFF;
      if ($urandom_range(3) == 0) ui = $urandom_range(4095);
      else ui = (ui + $urandom_range(16) - 8) & 12'hFFF;
      if ($urandom_range(7) == 0) ph = $urandom_range(1);
      if ($urandom_range(5) == 0)
        read_summary(ph[0], 1'($urandom_range(1)));
      else
        add_sample(ph[0], $urandom_range(3) == 0 ? 12'($urandom) : base[11:0],
                   12'((base + $urandom_range(8) - 4) & 12'hFFF), ui[11:0]);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty banks, field extremes, threshold edges, inverted and degenerate scales.
    read_all();
    add_sample(1'b0, 12'd0, 12'hFFF, 12'd0);
    add_sample(1'b0, 12'hFFF, 12'd0, 12'd5);
    add_sample(1'b0, 12'hAAA, 12'h555, 12'd9);
    add_sample(1'b1, 12'h555, 12'hAAA, 12'hFFF);
    add_sample(1'b1, 12'h7FF, 12'h800, 12'hFFB);
    read_all();
    set_calibration(12'd1000, 12'd3000, 1'b1, 12'd0);
    add_sample(1'b0, 12'd0, 12'd100, 12'd0);
    add_sample(1'b0, 12'hFFF, 12'd200, 12'd0);
    add_sample(1'b0, 12'd2000, 12'd300, 12'hFFF);
    read_all();
    set_calibration(12'd2048, 12'd2048, 1'b0, 12'hFFF);
    add_sample(1'b1, 12'd0, 12'd1, 12'd0);
    add_sample(1'b1, 12'hFFF, 12'd2, 12'hFFF);
    set_calibration(12'hFFF, 12'd0, 1'b1, 12'd1);
    add_sample(1'b1, 12'd5, 12'd3, 12'd1);
    add_sample(1'b1, 12'd6, 12'd4, 12'd1);
    read_all();

    // Random phases across a range of calibrations.
    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      send_idle_pct = (phase_no == 0) ? 16 : (phase_no == 1) ? 69 : 0;
      recv_idle_pct = (phase_no == 0) ? 69 : (phase_no == 1) ? 16 : 0;
      for (int j = 0; j < 4; j++) begin
        case ($urandom_range(3))
          0: set_calibration(12'd0, 12'hFFF, 1'($urandom_range(1)), 12'd5);
          1: set_calibration(12'($urandom), 12'($urandom), 1'($urandom_range(1)),
                             12'($urandom_range(20)));
          2: set_calibration(12'($urandom_range(500)), 12'($urandom_range(3500, 4095)),
                             1'($urandom_range(1)), 12'($urandom_range(2)));
          default: set_calibration(12'($urandom), 12'($urandom), 1'($urandom_range(1)),
                                   12'($urandom));
        endcase
        random_burst(100);
      end
      // Hold the receiver off while sending, so the unit backs up its input.
      if (phase_no == 1) begin
        hold_off_cycles = 3000;
        read_summary(1'b0, 1'b0);
        read_summary(1'b1, 1'b1);
        random_burst(20);
      end
    end
    set_calibration(12'd0, 12'hFFF, 1'b0, 12'd5);
    read_all();

    settle();
    $display("Sent %0d transactions over several calibrations and stall patterns;",
             items_sent);
    $display("%0d summaries compared against the prediction.", summaries_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
